[rtl/utfp_pkg.sv]
// Shared types and constants for the form body timing parser.
package utfp_pkg;

  localparam int KEY_COUNT = 5;
  localparam int KEY_LEN   = 6;
  localparam int VAL_W     = 14;

  localparam logic [2:0] NAME_SKIP = 3'd7;
  localparam logic [2:0] NAME_EQ   = 3'd6;
  localparam logic [4:0] ALL_KEYS  = 5'h1F;

  localparam logic [7:0] CHAR_AMP  = 8'h26;
  localparam logic [7:0] CHAR_EQ   = 8'h3D;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // Key names: b0h_ns, b0p_ns, b1h_ns, b1p_ns, rst_us
  localparam logic [7:0] KEY_TEXT [KEY_COUNT][KEY_LEN] = '{
    '{8'h62, 8'h30, 8'h68, 8'h5F, 8'h6E, 8'h73},
    '{8'h62, 8'h30, 8'h70, 8'h5F, 8'h6E, 8'h73},
    '{8'h62, 8'h31, 8'h68, 8'h5F, 8'h6E, 8'h73},
    '{8'h62, 8'h31, 8'h70, 8'h5F, 8'h6E, 8'h73},
    '{8'h72, 8'h73, 8'h74, 8'h5F, 8'h75, 8'h73}
  };

  typedef struct packed {
    logic                               form_ok;
    logic [KEY_COUNT-1:0][VAL_W-1:0]    values;
  } result_t;

endpackage

[rtl/utfp_in_if.sv]
// Input channel: one body byte per beat.
interface utfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic       last_byte;

  modport source (output valid, output body_byte, output last_byte, input ready);
  modport sink   (input valid, input body_byte, input last_byte, output ready);
endinterface

[rtl/utfp_out_if.sv]
// Output channel: one parse result per beat.
interface utfp_out_if;
  logic        valid;
  logic        ready;
  logic        form_ok;
  logic [13:0] zero_high_time;
  logic [13:0] zero_period_time;
  logic [13:0] one_high_time;
  logic [13:0] one_period_time;
  logic [13:0] latch_time;

  modport source (output valid, output form_ok, output zero_high_time,
                  output zero_period_time, output one_high_time,
                  output one_period_time, output latch_time, input ready);
  modport sink   (input valid, input form_ok, input zero_high_time,
                  input zero_period_time, input one_high_time,
                  input one_period_time, input latch_time, output ready);
endinterface

[rtl/utfp_parse_core.sv]
// Per-byte field scanner: key match, value conversion and result build.
module utfp_parse_core #(
  parameter int MAX_DIGITS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          body_byte,
  input  logic                last_byte,
  output utfp_pkg::result_t   result
);

  localparam logic [2:0] MAX_DIG = 3'(MAX_DIGITS);
  localparam int VW = utfp_pkg::VAL_W;
  localparam int NK = utfp_pkg::KEY_COUNT;

  logic [2:0]    name_position;
  logic [4:0]    key_match_mask;
  logic          in_value;
  logic [2:0]    value_key;
  logic [2:0]    digit_count;
  logic          value_bad;
  logic [VW-1:0] accumulator;
  logic [4:0]    found_mask;
  logic          any_bad;
  logic [VW-1:0] stored_values [NK];

  logic [2:0]    t_np;
  logic [4:0]    t_mask;
  logic          t_inv;
  logic [2:0]    t_vk;
  logic [2:0]    t_dc;
  logic          t_bad;
  logic [VW-1:0] t_acc;

  logic          e_inv;
  logic [2:0]    e_vk;
  logic [2:0]    e_dc;
  logic          e_bad;
  logic [VW-1:0] e_acc;

  logic          is_amp;
  logic          is_digit;
  logic          close_field;
  logic          write_value;
  logic          bad_now;
  logic [2:0]    first_key;
  logic [4:0]    found_next;
  logic          any_bad_next;
  logic          ok;
  logic [VW-1:0] acc_times_ten;

  assign is_amp   = (body_byte == utfp_pkg::CHAR_AMP);
  assign is_digit = (body_byte >= utfp_pkg::CHAR_ZERO) && (body_byte <= utfp_pkg::CHAR_NINE);
  assign acc_times_ten = (accumulator << 3) + (accumulator << 1);

  // Lowest matching key wins; falls to the last key when none match.
  always_comb begin
    first_key = 3'(NK - 1);
    for (int k = NK - 2; k >= 0; k--) begin
      if (key_match_mask[k]) first_key = 3'(k);
    end
  end

  always_comb begin
    t_np   = name_position;
    t_mask = key_match_mask;
    t_inv  = in_value;
    t_vk   = value_key;
    t_dc   = digit_count;
    t_bad  = value_bad;
    t_acc  = accumulator;
    if (!is_amp) begin
      if (in_value) begin
        if (is_digit && (digit_count < MAX_DIG)) begin
          t_acc = acc_times_ten + VW'(body_byte[3:0]);
          t_dc  = digit_count + 3'd1;
        end else begin
          t_bad = 1'b1;
        end
      end else if (name_position < utfp_pkg::NAME_EQ) begin
        for (int k = 0; k < NK; k++) begin
          if (utfp_pkg::KEY_TEXT[k][name_position] != body_byte) t_mask[k] = 1'b0;
        end
        t_np = name_position + 3'd1;
      end else if (name_position == utfp_pkg::NAME_EQ) begin
        t_np = utfp_pkg::NAME_SKIP;
        if ((body_byte == utfp_pkg::CHAR_EQ) && (key_match_mask != 5'd0)
            && !found_mask[first_key]) begin
          t_inv = 1'b1;
          t_vk  = first_key;
        end
      end
    end
  end

  // '&' closes the field as it stood before this byte; the end of body closes it after.
  always_comb begin
    if (is_amp) begin
      e_inv = in_value;
      e_vk  = value_key;
      e_dc  = digit_count;
      e_bad = value_bad;
      e_acc = accumulator;
    end else begin
      e_inv = t_inv;
      e_vk  = t_vk;
      e_dc  = t_dc;
      e_bad = t_bad;
      e_acc = t_acc;
    end
  end

  assign close_field  = is_amp || last_byte;
  assign write_value  = close_field && e_inv && (e_dc != 3'd0) && !e_bad;
  assign bad_now      = close_field && e_inv && ((e_dc == 3'd0) || e_bad);
  assign found_next   = found_mask | ((close_field && e_inv) ? 5'(5'b1 << e_vk) : 5'd0);
  assign any_bad_next = any_bad | bad_now;
  assign ok           = (found_next == utfp_pkg::ALL_KEYS) && !any_bad_next;

  always_comb begin
    result.form_ok = ok;
    for (int k = 0; k < NK; k++) begin
      if (!ok) begin
        result.values[k] = '0;
      end else if (write_value && (e_vk == 3'(k))) begin
        result.values[k] = e_acc;
      end else begin
        result.values[k] = stored_values[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      name_position  <= 3'd0;
      key_match_mask <= utfp_pkg::ALL_KEYS;
      in_value       <= 1'b0;
      value_key      <= 3'd0;
      digit_count    <= 3'd0;
      value_bad      <= 1'b0;
      accumulator    <= '0;
      found_mask     <= 5'd0;
      any_bad        <= 1'b0;
    end else if (fire) begin
      if (close_field) begin
        name_position  <= 3'd0;
        key_match_mask <= utfp_pkg::ALL_KEYS;
        in_value       <= 1'b0;
        value_key      <= 3'd0;
        digit_count    <= 3'd0;
        value_bad      <= 1'b0;
        accumulator    <= '0;
      end else begin
        name_position  <= t_np;
        key_match_mask <= t_mask;
        in_value       <= t_inv;
        value_key      <= t_vk;
        digit_count    <= t_dc;
        value_bad      <= t_bad;
        accumulator    <= t_acc;
      end
      found_mask <= last_byte ? 5'd0 : found_next;
      any_bad    <= last_byte ? 1'b0 : any_bad_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && write_value) stored_values[e_vk] <= e_acc;
  end

endmodule

[rtl/urlencoded_timing_form_parser.sv]
// Top level: input beat register, field scanner and result register.
// The last byte passes the input register; its result then loads the result register.
// Throughput: one body byte per cycle; the scanner updates once per byte.
// A pending result stalls only the final byte of the next body, never its other bytes.
// Reset (rst, synchronous): empties both registers and returns the scanner to the
// start of a body; stored field values are not cleared.
module urlencoded_timing_form_parser #(
  parameter int MAX_DIGITS = 4
) (
  input  logic      clk,
  input  logic      rst,
  utfp_in_if.sink   form_in,
  utfp_out_if.source form_out
);

  logic              in_valid;
  logic [7:0]        body_byte;
  logic              last_byte;
  logic              advance;
  logic              out_valid;
  utfp_pkg::result_t result;
  utfp_pkg::result_t out_data;

  // Bytes that make no result never wait on the output side.
  assign advance       = in_valid && (!last_byte || !out_valid || form_out.ready);
  assign form_in.ready = !in_valid || advance;

  utfp_parse_core #(.MAX_DIGITS(MAX_DIGITS)) u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .body_byte (body_byte),
    .last_byte (last_byte),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (form_in.ready) begin
      in_valid <= form_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (form_in.valid && form_in.ready) begin
      body_byte <= form_in.body_byte;
      last_byte <= form_in.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && last_byte) begin
      out_valid <= 1'b1;
    end else if (form_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last_byte) out_data <= result;
  end

  assign form_out.valid            = out_valid;
  assign form_out.form_ok          = out_data.form_ok;
  assign form_out.zero_high_time   = out_data.values[0];
  assign form_out.zero_period_time = out_data.values[1];
  assign form_out.one_high_time    = out_data.values[2];
  assign form_out.one_period_time  = out_data.values[3];
  assign form_out.latch_time       = out_data.values[4];

endmodule

[rtl/utfp_checker.sv]
// Port-level checks for the parser, bound to the top level.
module utfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        form_ok,
  input logic [13:0] zero_high_time,
  input logic [13:0] zero_period_time,
  input logic [13:0] one_high_time,
  input logic [13:0] one_period_time,
  input logic [13:0] latch_time
);

  localparam logic [13:0] VAL_MAX = 14'd9999;

  logic [69:0] payload;
  assign payload = {zero_high_time, zero_period_time, one_high_time,
                    one_period_time, latch_time};

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(payload) && $stable(form_ok))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !form_ok |-> payload == 70'd0)
    else $error("failed form carries nonzero values");

  a_ok_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && form_ok |-> zero_high_time <= VAL_MAX && zero_period_time <= VAL_MAX
      && one_high_time <= VAL_MAX && one_period_time <= VAL_MAX && latch_time <= VAL_MAX)
    else $error("value exceeds four digits");

endmodule

bind urlencoded_timing_form_parser utfp_checker u_utfp_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (form_out.valid),
  .out_ready        (form_out.ready),
  .form_ok          (form_out.form_ok),
  .zero_high_time   (form_out.zero_high_time),
  .zero_period_time (form_out.zero_period_time),
  .one_high_time    (form_out.one_high_time),
  .one_period_time  (form_out.one_period_time),
  .latch_time       (form_out.latch_time)
);

[test/tb_urlencoded_timing_form_parser.sv]
// Form body timing parser testbench: directed and random bodies, local predictor, scoreboard.
module tb_urlencoded_timing_form_parser;

  localparam int MAX_DIGITS   = 4;
  localparam int HOLD_CYCLES  = 300;
  localparam int STUCK_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int BYTE_TARGET  = 1550;
  localparam int BODY_TARGET  = 48;

  // Tracks the field scan of each body and queues the parse result it must yield.
  class timing_form_checker;
    string key_name[utfp_pkg::KEY_COUNT];
    string field_name[utfp_pkg::KEY_COUNT];
    bit [2:0] name_pos;
    bit [4:0] match_mask;
    bit in_val;
    bit [2:0] val_key;
    bit [2:0] digits;
    bit val_bad;
    bit [utfp_pkg::VAL_W-1:0] acc;
    bit [4:0] found;
    bit bad_seen;
    bit [utfp_pkg::VAL_W-1:0] stored[utfp_pkg::KEY_COUNT];
    utfp_pkg::result_t pending_forms[$];
    int errors;

    function new();
      key_name   = '{"b0h_ns", "b0p_ns", "b1h_ns", "b1p_ns", "rst_us"};
      field_name = '{"zero_high_time", "zero_period_time", "one_high_time",
                     "one_period_time", "latch_time"};
      found = '0;
      bad_seen = 1'b0;
      errors = 0;
      open_field();
    endfunction

    function void open_field();
      name_pos = '0;
      match_mask = utfp_pkg::ALL_KEYS;
      in_val = 1'b0;
      val_key = '0;
      digits = '0;
      val_bad = 1'b0;
      acc = '0;
    endfunction

    function void close_field();
      if (in_val) begin
        if (digits == 0 || val_bad) bad_seen = 1'b1;
        else stored[val_key] = acc;
        found[val_key] = 1'b1;
      end
      open_field();
    endfunction

    function void note_byte(logic [7:0] c, logic last);
      utfp_pkg::result_t r;
      int k;
      if (c == utfp_pkg::CHAR_AMP) begin
        close_field();
      end else if (in_val) begin
        if (c >= utfp_pkg::CHAR_ZERO && c <= utfp_pkg::CHAR_NINE && digits < MAX_DIGITS) begin
          acc = utfp_pkg::VAL_W'(int'(acc) * 10 + int'(c) - int'(utfp_pkg::CHAR_ZERO));
          digits++;
        end else begin
          val_bad = 1'b1;
        end
      end else if (name_pos < utfp_pkg::KEY_LEN) begin
        for (k = 0; k < utfp_pkg::KEY_COUNT; k++)
          if (key_name[k][name_pos] != c) match_mask[k] = 1'b0;
        name_pos++;
      end else if (name_pos == utfp_pkg::NAME_EQ) begin
        name_pos = utfp_pkg::NAME_SKIP;
        if (c == utfp_pkg::CHAR_EQ && match_mask != 0) begin
          k = 0;
          while (k < utfp_pkg::KEY_COUNT - 1 && !match_mask[k]) k++;
          // only the first occurrence of a key opens a value
          if (!found[k]) begin
            in_val = 1'b1;
            val_key = 3'(k);
          end
        end
      end
      if (last) begin
        close_field();
        r.form_ok = (found == utfp_pkg::ALL_KEYS) && !bad_seen;
        for (k = 0; k < utfp_pkg::KEY_COUNT; k++) r.values[k] = r.form_ok ? stored[k] : '0;
        pending_forms.push_back(r);
        open_field();
        found = '0;
        bad_seen = 1'b0;
      end
    endfunction

    function void check_form(utfp_pkg::result_t got);
      utfp_pkg::result_t want;
      int k;
      if (pending_forms.size() == 0) begin
        $display("%0t: unexpected result: expected none, got form_ok=%b", $time, got.form_ok);
        errors++;
        return;
      end
      want = pending_forms.pop_front();
      if (want.form_ok !== got.form_ok) begin
        $display("%0t: form_ok expected %b got %b", $time, want.form_ok, got.form_ok);
        errors++;
      end
      for (k = 0; k < utfp_pkg::KEY_COUNT; k++)
        if (want.values[k] !== got.values[k]) begin
          $display("%0t: %s expected %0d got %0d", $time, field_name[k],
                   want.values[k], got.values[k]);
          errors++;
        end
    endfunction
  endclass

  logic clk;
  logic rst;
  utfp_in_if  form_in();
  utfp_out_if form_out();

  urlencoded_timing_form_parser #(.MAX_DIGITS(MAX_DIGITS)) uut (
    .clk      (clk),
    .rst      (rst),
    .form_in  (form_in),
    .form_out (form_out)
  );

  timing_form_checker chk = new();

  logic [7:0] body_q[$];
  int sender_idle_pct = 0;
  int sink_stall_pct = 0;
  bit hold_req = 1'b0;
  int bytes_sent = 0;
  int bodies_sent = 0;
  int stuck_cycles = 0;
  bit in_beat;
  bit out_beat;
  utfp_pkg::result_t got_form;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Sample both channels and watch for a hung handshake.
  always @(posedge clk) begin
    if (!rst) begin
      in_beat  = form_in.valid && form_in.ready;
      out_beat = form_out.valid && form_out.ready;
      if (out_beat) begin
        got_form.form_ok   = form_out.form_ok;
        got_form.values[0] = form_out.zero_high_time;
        got_form.values[1] = form_out.zero_period_time;
        got_form.values[2] = form_out.one_high_time;
        got_form.values[3] = form_out.one_period_time;
        got_form.values[4] = form_out.latch_time;
        chk.check_form(got_form);
      end
      if (in_beat) chk.note_byte(form_in.body_byte, form_in.last_byte);
      if (in_beat || out_beat) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    form_out.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        form_out.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        form_out.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  function automatic void add_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) body_q.push_back(s[i]);
  endfunction

  function automatic void add_sep();
    if (body_q.size() != 0) body_q.push_back(utfp_pkg::CHAR_AMP);
  endfunction

  function automatic void add_number(int n, int width);
    int div;
    int i;
    div = 1;
    repeat (width - 1) div *= 10;
    for (i = 0; i < width; i++) begin
      body_q.push_back(8'(int'(utfp_pkg::CHAR_ZERO) + (n / div) % 10));
      div /= 10;
    end
  endfunction

  function automatic logic [7:0] non_digit();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == utfp_pkg::CHAR_AMP ||
           (b >= utfp_pkg::CHAR_ZERO && b <= utfp_pkg::CHAR_NINE));
    return b;
  endfunction

  function automatic logic [7:0] noise_byte();
    string key_chars;
    int r;
    key_chars = "b0h1p_nsrtu";
    r = $urandom_range(99);
    if (r < 30) return 8'(int'(utfp_pkg::CHAR_ZERO) + $urandom_range(9));
    if (r < 40) return utfp_pkg::CHAR_EQ;
    if (r < 50) return utfp_pkg::CHAR_AMP;
    if (r < 70) return key_chars[$urandom_range(key_chars.len() - 1)];
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic void add_value();
    int r;
    int w;
    r = $urandom_range(99);
    // 88..91 leave the value empty
    if (r < 88) begin
      w = $urandom_range(1, MAX_DIGITS);
      add_number($urandom_range(10 ** w - 1), w);
    end else if (r >= 92 && r < 96) begin
      w = $urandom_range(MAX_DIGITS + 1, MAX_DIGITS + 2);
      add_number($urandom_range(10 ** w - 1), w);
    end else if (r >= 96) begin
      add_number($urandom_range(99), 2);
      body_q.push_back(non_digit());
      add_number($urandom_range(9), 1);
    end
  endfunction

  function automatic void add_noise_field();
    int r;
    int k;
    string key;
    r = $urandom_range(99);
    k = $urandom_range(utfp_pkg::KEY_COUNT - 1);
    key = chk.key_name[k];
    if (r < 35) begin
      repeat ($urandom_range(8)) body_q.push_back(noise_byte());
    end else if (r < 60) begin
      // near miss: one name character replaced
      add_text(key);
      body_q[body_q.size() - 1 - $urandom_range(utfp_pkg::KEY_LEN - 1)] = noise_byte();
      body_q.push_back(utfp_pkg::CHAR_EQ);
      add_number($urandom_range(99), 2);
    end else if (r < 80) begin
      add_text(key);
    end else begin
      if ($urandom_range(1)) begin
        add_text(key.substr(0, $urandom_range(4)));
      end else begin
        add_text(key);
        body_q.push_back(noise_byte());
      end
      body_q.push_back(utfp_pkg::CHAR_EQ);
      add_number($urandom_range(9), 1);
    end
  endfunction

  task automatic send_beat(logic [7:0] b, logic l);
    while ($urandom_range(99) < sender_idle_pct) begin
      form_in.valid <= 1'b0;
      @(posedge clk);
    end
    form_in.valid     <= 1'b1;
    form_in.body_byte <= b;
    form_in.last_byte <= l;
    @(posedge clk);
    while (!form_in.ready) @(posedge clk);
  endtask

  task automatic send_body();
    int i;
    if (body_q.size() == 0) body_q.push_back(utfp_pkg::CHAR_AMP);
    for (i = 0; i < body_q.size(); i++) send_beat(body_q[i], i == body_q.size() - 1);
    bytes_sent += body_q.size();
    bodies_sent++;
    body_q.delete();
  endtask

  task automatic send_text(string s);
    add_text(s);
    send_body();
  endtask

  task automatic send_random_body();
    int order[utfp_pkg::KEY_COUNT];
    int r;
    int i;
    int j;
    int t;
    r = $urandom_range(99);
    if (r < 60) begin
      // well-formed body with the keys shuffled and occasional defects
      for (i = 0; i < utfp_pkg::KEY_COUNT; i++) order[i] = i;
      for (i = utfp_pkg::KEY_COUNT - 1; i > 0; i--) begin
        j = $urandom_range(i);
        t = order[i];
        order[i] = order[j];
        order[j] = t;
      end
      for (i = 0; i < utfp_pkg::KEY_COUNT; i++) begin
        if ($urandom_range(99) < 15) begin
          add_sep();
          add_noise_field();
        end
        if ($urandom_range(99) < 5) continue;
        add_sep();
        add_text(chk.key_name[order[i]]);
        body_q.push_back(utfp_pkg::CHAR_EQ);
        add_value();
        if ($urandom_range(99) < 10) begin
          add_sep();
          add_text(chk.key_name[order[$urandom_range(i)]]);
          body_q.push_back(utfp_pkg::CHAR_EQ);
          add_value();
        end
      end
      if ($urandom_range(99) < 10) body_q.push_back(utfp_pkg::CHAR_AMP);
    end else if (r < 80) begin
      repeat ($urandom_range(1, 12)) body_q.push_back(noise_byte());
    end else begin
      repeat ($urandom_range(1, 3)) begin
        add_sep();
        add_noise_field();
      end
    end
    send_body();
  endtask

  initial begin
    int chunk;
    rst = 1'b1;
    form_in.valid = 1'b0;
    form_in.body_byte = '0;
    form_in.last_byte = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed bodies
    send_text("b0h_ns=9999&b0p_ns=9999&b1h_ns=9999&b1p_ns=9999&rst_us=9999");
    send_text("rst_us=0&b1p_ns=0&b1h_ns=0&b0p_ns=0&b0h_ns=0&");
    send_text("&");
    send_text("b0h_ns=12&b0h_ns=xx&b0p_ns=0042&b1h_ns=7&b1p_ns=300&rst_us=50&b1p_ns=");
    send_text("b0h_ns=&b0p_ns=1&b1h_ns=2&b1p_ns=3&rst_us=4");
    send_text("b0h_ns=1&b0p_ns=1&b1h_ns&b1h_ns=5&b1p_ns=1&b1p_ns&rst_us=1");
    send_text("b0h_ns=1&b0p_ns=1&b1h_ns=1&b1p_ns&rst_us=1");
    send_text("b0h_ns=12345&b0p_ns=1&b1h_ns=1&b1p_ns=1&rst_us=1");
    add_text("b0h_ns=1");
    body_q.push_back(8'h00);
    add_text("2&b0h");
    body_q.push_back(8'h00);
    send_text("ns=5&b0p_ns=1&b1h_ns=1&b1p_ns=1&rst_us=1");
    send_text("b0h_nsx=5&b0h_n=5&&b0h_ns=5&b0p_ns=5&b1h_ns=5&b1p_ns=5&rst_us=9&&");
    body_q.push_back(8'hFF);
    send_body();
    send_text("b0h_ns=1&b0p_ns=1&b1h_ns=1&b1p_ns=1&rst_us=");

    // random bodies over rotating idle phases
    chunk = 0;
    while (bytes_sent < BYTE_TARGET || bodies_sent < BODY_TARGET) begin
      case (chunk % 4)
        0: begin
          sender_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 55;
          sink_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          sink_stall_pct = 55;
        end
        default: begin
          sender_idle_pct = 16;
          sink_stall_pct = 16;
        end
      endcase
      // hold the result side off while bodies keep coming, to back up the input
      if (chunk == 4) hold_req = 1'b1;
      repeat (5) send_random_body();
      chunk++;
    end
    form_in.valid <= 1'b0;

    while (chk.pending_forms.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (chk.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

[filelist.f]
rtl/utfp_pkg.sv
rtl/utfp_in_if.sv
rtl/utfp_out_if.sv
rtl/utfp_parse_core.sv
rtl/urlencoded_timing_form_parser.sv
rtl/utfp_checker.sv
test/tb_urlencoded_timing_form_parser.sv
